// ===== rtl/hwm_pkg.sv =====
// Shared constants for the multilevel Haar wavelet block.
`default_nettype none

package hwm_pkg;

    localparam int DEF_POINTS      = 16;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int QUEUE_DEPTH     = 2;

endpackage

`default_nettype wire

// ===== rtl/hwm_front.sv =====
// Front end: accepts sample beats, scales them and tags each with its frame position.
`default_nettype none

module hwm_front #(
    parameter int POINTS      = hwm_pkg::DEF_POINTS,
    parameter int SAMPLE_BITS = hwm_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             s_tvalid,
    output logic                                                  s_tready,
    input  wire logic [SAMPLE_BITS-1:0]                           sample,
    input  wire logic                                             q_full,
    output logic                                                  q_push,
    output logic [SAMPLE_BITS+2*$clog2(POINTS):0]                 q_data
);

    localparam int L = $clog2(POINTS);

    logic [L-1:0] count_reg;
    logic         last;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign last     = (count_reg == L'(POINTS - 1));

    // Entry layout from the lowest bit: scaled sample, position, last flag.
    // Appending L zero bits scales the sample by 2^L with its sign kept.
    assign q_data = {last, count_reg, sample, {L{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_reg + L'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hwm_fifo.sv =====
// Small queue between the front end and the transform engine.
`default_nettype none

module hwm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hwm_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    output logic                  valid,
    output logic [WIDTH-1:0]      dout,
    input  wire logic             pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hwm_back.sv =====
// Transform engine: stores the frame, runs the Haar levels and streams the coefficients.
`default_nettype none

module hwm_back #(
    parameter int POINTS      = hwm_pkg::DEF_POINTS,
    parameter int SAMPLE_BITS = hwm_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        q_valid,
    input  wire logic [SAMPLE_BITS+2*$clog2(POINTS):0]       q_data,
    output logic                                             q_pop,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [SAMPLE_BITS+$clog2(POINTS)-1:0]            coefficient,
    output logic [$clog2(POINTS)-1:0]                        position,
    output logic                                             final_res
);

    localparam int L  = $clog2(POINTS);
    localparam int CW = SAMPLE_BITS + L;

    typedef enum logic [1:0] {
        S_LOAD,
        S_CALC,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic [L-1:0]  half_reg;
    logic [L-1:0]  pair_reg;
    logic          calc_vld_reg;
    logic [L-1:0]  calc_i_reg;
    logic [L-1:0]  calc_half_reg;
    logic [CW-1:0] ra_reg;
    logic [CW-1:0] rb_reg;
    logic [CW-1:0] final_avg_reg;
    logic [L-1:0]  emit_k_reg;
    logic          pend_reg;
    logic [L-1:0]  pend_pos_reg;
    logic [CW-1:0] coef_rd_reg;
    logic          m_valid_reg;
    logic [CW-1:0] m_coef_reg;
    logic [L-1:0]  m_pos_reg;
    logic          m_last_reg;

    logic [CW-1:0] work_mem [POINTS];
    logic [CW-1:0] coef_mem [POINTS];

    logic [CW-1:0] q_value;
    logic [L-1:0]  q_idx;
    logic          q_last;
    logic          load_wr;
    logic          emit_issue;
    logic [L-1:0]  addr_a;
    logic [L-1:0]  addr_b;
    logic [CW:0]   sum;
    logic [CW:0]   dif;
    logic [CW-1:0] avg;
    logic [CW-1:0] half_dif;
    logic          work_we;
    logic [L-1:0]  work_waddr;
    logic [CW-1:0] work_wdata;

    assign q_value = q_data[CW-1:0];
    assign q_idx   = q_data[CW+L-1:CW];
    assign q_last  = q_data[CW+L];

    assign load_wr    = (state_reg == S_LOAD) && q_valid;
    assign q_pop      = load_wr;
    assign emit_issue = (state_reg == S_EMIT) && !pend_reg && (!m_valid_reg || m_tready);

    // Pair i of a level reads entries 2i and 2i+1.
    assign addr_a = pair_reg << 1;
    assign addr_b = addr_a | L'(1);

    // The operands carry enough zero fraction bits that the halving is exact.
    assign sum      = {ra_reg[CW-1], ra_reg} + {rb_reg[CW-1], rb_reg};
    assign dif      = {ra_reg[CW-1], ra_reg} - {rb_reg[CW-1], rb_reg};
    assign avg      = sum[CW:1];
    assign half_dif = dif[CW:1];

    // Averages go back in place: entry i is written only after pair i/2 has read it.
    always_comb
    begin
        work_we    = 1'b0;
        work_waddr = q_idx;
        work_wdata = q_value;
        if (calc_vld_reg)
        begin
            work_we    = 1'b1;
            work_waddr = calc_i_reg;
            work_wdata = avg;
        end
        else if (load_wr)
        begin
            work_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        ra_reg <= work_mem[addr_a];
        rb_reg <= work_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (calc_vld_reg)
        begin
            coef_mem[calc_half_reg + calc_i_reg] <= half_dif;
        end
        if (emit_issue)
        begin
            coef_rd_reg <= coef_mem[emit_k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_vld_reg && (calc_half_reg == L'(1)))
        begin
            final_avg_reg <= avg;
        end
        pend_pos_reg <= emit_k_reg;
        calc_i_reg   <= pair_reg;
        calc_half_reg <= half_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            half_reg     <= L'(POINTS / 2);
            pair_reg     <= '0;
            calc_vld_reg <= 1'b0;
            emit_k_reg   <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_coef_reg   <= '0;
            m_pos_reg    <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            calc_vld_reg <= (state_reg == S_CALC);
            pend_reg     <= emit_issue;
            if (pend_reg)
            begin
                m_valid_reg <= 1'b1;
                // Position zero holds the overall average, kept outside the memory.
                m_coef_reg  <= (pend_pos_reg == '0) ? final_avg_reg : coef_rd_reg;
                m_pos_reg   <= pend_pos_reg;
                m_last_reg  <= (pend_pos_reg == L'(POINTS - 1));
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (load_wr && q_last)
                    begin
                        state_reg <= S_CALC;
                        half_reg  <= L'(POINTS / 2);
                        pair_reg  <= '0;
                    end
                end
                S_CALC:
                begin
                    if (pair_reg == half_reg - L'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        pair_reg <= pair_reg + L'(1);
                    end
                end
                S_DRAIN:
                begin
                    // This idle state lets the last average of a level land
                    // before the next level reads it.
                    if (half_reg == L'(1))
                    begin
                        state_reg  <= S_EMIT;
                        emit_k_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_CALC;
                        half_reg  <= half_reg >> 1;
                        pair_reg  <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (emit_issue)
                    begin
                        emit_k_reg <= emit_k_reg + L'(1);
                        if (emit_k_reg == L'(POINTS - 1))
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign coefficient = m_coef_reg;
    assign position    = m_pos_reg;
    assign final_res   = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/haar_wavelet_multilevel.sv =====
// Top level of the multilevel Haar wavelet decomposition block.
// The block collects a frame of POINTS signed samples, one per input beat, scales each by
// 2^L with L = log2(POINTS), and after the last sample runs the full Haar decomposition:
// every level writes pairwise averages to the front half of the span and half-differences
// to the back half, until the span is one. It then sends the POINTS coefficients in array
// order, with tlast on the last one. Samples are loaded through a two-entry queue. The
// transform handles one pair at a time, set by the single two-read, one-write port of the
// working memory, and each level ends in an idle drain state. Emission issues the next
// coefficient read only after the registered read of the previous one from the coefficient
// memory has been passed on. Up to two samples of the next frame are queued meanwhile. No
// clearing pass is needed after reset.
`default_nettype none

module haar_wavelet_multilevel #(
    parameter int POINTS      = hwm_pkg::DEF_POINTS,
    parameter int SAMPLE_BITS = hwm_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                                clk,
    input  wire logic                                                rst_n,
    input  wire logic                                                s_tvalid,
    output logic                                                     s_tready,
    // Fields from bit 0: sample.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]                    s_tdata,
    output logic                                                     m_tvalid,
    input  wire logic                                                m_tready,
    // Fields from bit 0: coefficient, position.
    output logic [((SAMPLE_BITS+2*$clog2(POINTS)+7)/8)*8-1:0]        m_tdata,
    output logic                                                     m_tlast
);

    localparam int L     = $clog2(POINTS);
    localparam int CW    = SAMPLE_BITS + L;
    localparam int EW    = CW + L + 1;
    localparam int OUT_W = ((CW + L + 7) / 8) * 8;

    logic          q_full;
    logic          q_push;
    logic [EW-1:0] q_din;
    logic          q_valid;
    logic [EW-1:0] q_dout;
    logic          q_pop;
    logic [CW-1:0] coefficient;
    logic [L-1:0]  position;

    hwm_front #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_din)
    );

    hwm_fifo #(
        .WIDTH (EW),
        .DEPTH (hwm_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_dout),
        .pop   (q_pop)
    );

    hwm_back #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_dout),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .coefficient (coefficient),
        .position    (position),
        .final_res   (m_tlast)
    );

    assign m_tdata = OUT_W'({position, coefficient});

    // The engine only takes a queue entry that is really there.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // The beat that closes a frame carries the highest position.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[CW+L-1:CW] == L'(POINTS - 1)))
        else $error("tlast on a beat that is not the last coefficient");

    // A full queue always pushes back on the sample side.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !q_push || !$past(q_full))
        else $error("sample accepted into a full queue");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the multilevel Haar wavelet block.
module tb;

    localparam int POINTS      = hwm_pkg::DEF_POINTS;
    localparam int SBITS       = hwm_pkg::DEF_SAMPLE_BITS;
    localparam int LOG2P       = $clog2(POINTS);
    localparam int CBITS       = SBITS + LOG2P;
    localparam int IN_W        = ((SBITS + 7) / 8) * 8;
    localparam int OUT_W       = ((SBITS + 2 * LOG2P + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CBITS-1:0] coef;
        logic [LOG2P-1:0] pos;
        logic             last;
    } coef_beat_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    logic [IN_W-1:0]  sample_queue [$];
    coef_beat_t       pending_coefs [$];
    longint           frame_samples [POINTS];
    int               frame_fill     = 0;
    int               src_idle_pct   = 0;
    int               sink_idle_pct  = 0;
    int               hold_requests  = 0;
    int               holds_served   = 0;
    int               hold_left      = 0;
    int               fail_count     = 0;
    int               stall_cycles   = 0;
    bit               sample_taken   = 1'b0;

    haar_wavelet_multilevel #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SBITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stores one scaled sample; the last one of a frame triggers the full
    // decomposition and queues all coefficients in array order.
    task automatic absorb_sample(input logic [IN_W-1:0] raw);
        longint cur [POINTS];
        longint nxt [POINTS];
        int     span;
        int     half;
        coef_beat_t beat;
        frame_samples[frame_fill] = longint'($signed(raw[SBITS-1:0])) * POINTS;
        if (frame_fill < POINTS - 1)
        begin
            frame_fill++;
            return;
        end
        frame_fill = 0;
        cur = frame_samples;
        nxt = frame_samples;
        for (span = POINTS; span > 1; span = span / 2)
        begin
            half = span / 2;
            for (int i = 0; i < half; i++)
            begin
                nxt[i]        = (cur[2 * i] + cur[2 * i + 1]) / 2;
                nxt[half + i] = (cur[2 * i] - cur[2 * i + 1]) / 2;
            end
            for (int i = 0; i < span; i++)
                cur[i] = nxt[i];
        end
        for (int k = 0; k < POINTS; k++)
        begin
            beat.coef = cur[k][CBITS-1:0];
            beat.pos  = k[LOG2P-1:0];
            beat.last = (k == POINTS - 1);
            pending_coefs.push_back(beat);
        end
    endtask

    // Full-range noise half the time, with small values and values at or near the
    // extremes mixed in.
    function automatic logic [IN_W-1:0] pick_sample();
        int unsigned      mode;
        logic [SBITS-1:0] v;
        logic [SBITS-1:0] top;
        logic [SBITS-1:0] bottom;
        top    = {1'b0, {(SBITS-1){1'b1}}};
        bottom = {1'b1, {(SBITS-1){1'b0}}};
        mode   = $urandom_range(99);
        if (mode < 50)
            v = SBITS'($urandom);
        else if (mode < 70)
            v = SBITS'($urandom_range(128)) - SBITS'(64);
        else if (mode < 85)
        begin
            case ($urandom_range(3))
                0:       v = top;
                1:       v = bottom;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        else if ($urandom_range(1) == 1)
            v = top - SBITS'($urandom_range(7));
        else
            v = bottom + SBITS'($urandom_range(7));
        pick_sample = '0;
        pick_sample[SBITS-1:0] = v;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            sample_queue.push_back(pick_sample());
    endtask

    task automatic wait_for_drain();
        while (sample_queue.size() != 0 || s_tvalid || pending_coefs.size() != 0)
            @(posedge clk);
    endtask

    // Input driver: a beat stays up until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || sample_taken))
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure, plus long hold-offs on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served < hold_requests)
        begin
            m_tready     <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: checks coefficient beats, feeds accepted samples to the
    // predictor and watches for a hang.
    always @(posedge clk)
    begin
        coef_beat_t want;
        bit         out_beat;
        out_beat     = m_tvalid && m_tready;
        sample_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (out_beat)
            begin
                if (pending_coefs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Unexpected coefficient beat: data %h last %b",
                                 m_tdata, m_tlast);
                end
                else
                begin
                    want = pending_coefs.pop_front();
                    if (m_tdata[CBITS-1:0] !== want.coef
                        || m_tdata[CBITS+LOG2P-1:CBITS] !== want.pos
                        || m_tlast !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                     want.coef, want.pos, want.last,
                                     m_tdata[CBITS-1:0], m_tdata[CBITS+LOG2P-1:CBITS],
                                     m_tlast);
                    end
                end
            end
            if (sample_taken)
                absorb_sample(s_tdata);
            if (out_beat || sample_taken)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int directed_vals [POINTS];
        directed_vals = '{32767, -32768, 32767, -32768, 0, -1, 1, 0,
                          -32768, -32768, 32767, 32767,
                          21845, -21846, 255, -256};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Sender mostly busy, receiver mostly stalling.
        src_idle_pct  = 6;
        sink_idle_pct = 71;
        for (int i = 0; i < POINTS; i++)
            sample_queue.push_back(IN_W'(directed_vals[i][SBITS-1:0]));
        queue_random(10 * POINTS);
        wait_for_drain();

        // The other way round; this phase stops partway into a frame.
        src_idle_pct  = 71;
        sink_idle_pct = 6;
        queue_random(10 * POINTS + 5);
        wait_for_drain();

        // No idling, but one long hold-off so the block backs up its input.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_requests = 1;
        queue_random(11 * POINTS - 5);
        wait_for_drain();

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_coefs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hwm_pkg.sv
rtl/hwm_front.sv
rtl/hwm_fifo.sv
rtl/hwm_back.sv
rtl/haar_wavelet_multilevel.sv
verif/tb.sv
